// ----- hw/rtl/sidc_pkg.sv -----
`timescale 1ns / 1ps

package sidc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_WORDS = 4;
  localparam int WORD_W    = 64;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 5;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMEMBER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CULL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd3600;
  localparam logic [CNT_W-1:0]  CAPACITY_RST = 5'd16;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    key_t              key;
    logic [TIME_W-1:0] seen;
    logic              deliv;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic touch;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/seen_id_dedup_cache_unit.sv -----
`timescale 1ns / 1ps

// channel  | handshake                | payload
// in       | start, busy              | in_func, in_key_word0..3, in_delivered_in, in_now_time
// out      | out_valid (one cycle)    | out_found, out_was_delivered, out_evicted,
//          |                          | out_removed_count, out_entries_used
// cfg      | cfg_valid, cfg_ready     | cfg_index, cfg_wdata
//
// lookup, remember and unused codes pass through ST_EXEC, and their result is registered before the strobe
// cull passes through ST_EXEC and then stays in ST_CULL while entries are expired: the cell row drops one
// expired entry per cycle by shifting the cells above it down by one
// a new item is taken in the cycle its predecessor's result is shown
// synchronous reset empties the table; no clearing pass, entry contents are not reset
// results cannot be stalled, out_valid stands for exactly one cycle

module seen_id_dedup_cache_unit #(
  parameter int DEPTH = sidc_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sidc_pkg::FUNC_W-1:0]    in_func,
  input  logic [sidc_pkg::WORD_W-1:0]    in_key_word0,
  input  logic [sidc_pkg::WORD_W-1:0]    in_key_word1,
  input  logic [sidc_pkg::WORD_W-1:0]    in_key_word2,
  input  logic [sidc_pkg::WORD_W-1:0]    in_key_word3,
  input  logic                           in_delivered_in,
  input  logic [sidc_pkg::TIME_W-1:0]    in_now_time,
  output logic                           out_valid,
  output logic                           out_found,
  output logic                           out_was_delivered,
  output logic                           out_evicted,
  output logic [sidc_pkg::CNT_W-1:0]     out_removed_count,
  output logic [sidc_pkg::CNT_W-1:0]     out_entries_used,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sidc_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import sidc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_CULL} state_t;

  state_t             state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  key_t               key_r, key_nxt;
  logic               deliv_r, deliv_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      removed_r, removed_nxt;
  logic [TIME_W-1:0]  lifetime_r, lifetime_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_del_r, out_del_nxt;
  logic               out_evict_r, out_evict_nxt;
  logic [CNT_W-1:0]   out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;

  entry_t             cell_q [DEPTH];
  cell_ctrl_t         ctrl [DEPTH];
  logic [DEPTH-1:0]   valid_vec, match_vec, exp_vec, deliv_vec, cut_vec;
  logic [DEPTH-1:0]   load_vec, shift_vec, touch_vec;
  logic               do_load, shift_all, shift_cut, do_touch;
  logic [CW-1:0]      load_pos;
  logic [31:0]        limit;
  logic               full;
  logic               accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    assign valid_vec[i] = (CW'(i) < used_r);
    assign ctrl[i]      = '{load: load_vec[i], shift: shift_vec[i], touch: touch_vec[i]};
    assign deliv_vec[i] = cell_q[i].deliv;
    sidc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .valid    (valid_vec[i]),
      .key_in   (key_r),
      .now_in   (now_r),
      .deliv_in (deliv_r),
      .lifetime (lifetime_r),
      .nbr_in   (nbr),
      .q        (cell_q[i]),
      .match    (match_vec[i]),
      .expired  (exp_vec[i])
    );
  end

  // cells from the first expired entry upward shift down
  always_comb begin
    cut_vec[0] = exp_vec[0];
    for (int i = 1; i < DEPTH; i++) begin
      cut_vec[i] = cut_vec[i-1] | exp_vec[i];
    end
  end

  assign limit = ((cap_r == '0) || (32'(cap_r) > 32'(DEPTH))) ? 32'(DEPTH) : 32'(cap_r);
  assign full  = (32'(used_r) >= limit) && (used_r != '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      load_vec[i]  = do_load && (CW'(i) == load_pos);
      shift_vec[i] = shift_all || (shift_cut && cut_vec[i]);
      touch_vec[i] = do_touch && match_vec[i];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    key_nxt         = key_r;
    deliv_nxt       = deliv_r;
    now_nxt         = now_r;
    used_nxt        = used_r;
    removed_nxt     = removed_r;
    lifetime_nxt    = lifetime_r;
    cap_nxt         = cap_r;
    out_valid_nxt   = 1'b0;
    out_found_nxt   = out_found_r;
    out_del_nxt     = out_del_r;
    out_evict_nxt   = out_evict_r;
    out_removed_nxt = out_removed_r;
    out_used_nxt    = out_used_r;
    do_load         = 1'b0;
    load_pos        = used_r;
    shift_all       = 1'b0;
    shift_cut       = 1'b0;
    do_touch        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIFETIME: lifetime_nxt = cfg_wdata[TIME_W-1:0];
        REG_CAPACITY: cap_nxt      = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          key_nxt   = {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
          deliv_nxt = in_delivered_in;
          now_nxt   = in_now_time;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_found_nxt   = 1'b0;
        out_del_nxt     = 1'b0;
        out_evict_nxt   = 1'b0;
        out_removed_nxt = '0;
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_IDLE;
        case (func_r)
          FUNC_LOOKUP: begin
            out_found_nxt = |match_vec;
            out_del_nxt   = |(match_vec & deliv_vec);
          end
          FUNC_REMEMBER: begin
            if (|match_vec) begin
              out_found_nxt = 1'b1;
              do_touch      = 1'b1;
            end else if (full) begin
              // evict the oldest, new item lands in the top used slot
              shift_all     = 1'b1;
              do_load       = 1'b1;
              load_pos      = used_r - CW'(1);
              out_evict_nxt = 1'b1;
            end else if (32'(used_r) < 32'(DEPTH)) begin
              do_load  = 1'b1;
              used_nxt = used_r + CW'(1);
            end
          end
          FUNC_CULL: begin
            out_valid_nxt = 1'b0;
            removed_nxt   = '0;
            state_nxt     = ST_CULL;
          end
          default: ;
        endcase
      end
      ST_CULL: begin
        if (|exp_vec) begin
          shift_cut   = 1'b1;
          used_nxt    = used_r - CW'(1);
          removed_nxt = removed_r + CW'(1);
        end else begin
          out_removed_nxt = CNT_W'(removed_r);
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_valid_nxt) begin
      out_used_nxt = CNT_W'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      removed_r   <= '0;
      lifetime_r  <= LIFETIME_RST;
      cap_r       <= CAPACITY_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      removed_r   <= removed_nxt;
      lifetime_r  <= lifetime_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r        <= func_nxt;
    key_r         <= key_nxt;
    deliv_r       <= deliv_nxt;
    now_r         <= now_nxt;
    out_found_r   <= out_found_nxt;
    out_del_r     <= out_del_nxt;
    out_evict_r   <= out_evict_nxt;
    out_removed_r <= out_removed_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_was_delivered = out_del_r;
  assign out_evicted       = out_evict_r;
  assign out_removed_count = out_removed_r;
  assign out_entries_used  = out_used_r;

endmodule

// ----- hw/rtl/sidc_cell.sv -----
`timescale 1ns / 1ps

module sidc_cell (
  input  logic                        clk,
  input  sidc_pkg::cell_ctrl_t        ctrl,
  input  logic                        valid,
  input  sidc_pkg::key_t              key_in,
  input  logic [sidc_pkg::TIME_W-1:0] now_in,
  input  logic                        deliv_in,
  input  logic [sidc_pkg::TIME_W-1:0] lifetime,
  input  sidc_pkg::entry_t            nbr_in,
  output sidc_pkg::entry_t            q,
  output logic                        match,
  output logic                        expired
);
  import sidc_pkg::*;

  entry_t            q_r;
  entry_t            q_nxt;
  logic [TIME_W-1:0] age;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.load) begin
      q_nxt.key   = key_in;
      q_nxt.seen  = now_in;
      q_nxt.deliv = deliv_in;
    end else if (ctrl.shift) begin
      q_nxt = nbr_in;
    end else if (ctrl.touch) begin
      q_nxt.seen  = now_in;
      q_nxt.deliv = q_r.deliv | deliv_in;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign age     = now_in - q_r.seen;
  assign match   = valid && (q_r.key == key_in);
  assign expired = valid && ((q_r.seen == '0) || (now_in < q_r.seen) || (age > lifetime));
  assign q       = q_r;

endmodule

// ----- hw/rtl/sidc_checker.sv -----
`timescale 1ns / 1ps

module sidc_checker #(
  parameter int DEPTH = sidc_pkg::DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_found,
  input logic                       out_was_delivered,
  input logic                       out_evicted,
  input logic [sidc_pkg::CNT_W-1:0] out_removed_count,
  input logic [sidc_pkg::CNT_W-1:0] out_entries_used
);
  import sidc_pkg::*;

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // finishing an item always shows its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entries_used) <= 32'(DEPTH))
    else $error("entry count above table depth");

  a_deliv_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> !out_was_delivered)
    else $error("delivered flag on a miss");

  a_evict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_found && (out_removed_count == '0))
    else $error("eviction together with hit or cull");

endmodule

bind seen_id_dedup_cache_unit sidc_checker #(.DEPTH(DEPTH)) u_sidc_checker (.*);

// ----- dv/tb_seen_id_dedup_cache_unit.sv -----
`timescale 1ns / 1ps

module tb_seen_id_dedup_cache_unit;
  import sidc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int POOL_SIZE = 20;
  localparam int MAX_REPORTS = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    key_t              key;
    logic              deliv;
    logic [TIME_W-1:0] now;
  } cache_op_t;

  typedef struct packed {
    logic             found;
    logic             was_delivered;
    logic             evicted;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] entries_used;
  } dedup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = FUNC_LOOKUP;
  logic [WORD_W-1:0] in_key_word0 = '0;
  logic [WORD_W-1:0] in_key_word1 = '0;
  logic [WORD_W-1:0] in_key_word2 = '0;
  logic [WORD_W-1:0] in_key_word3 = '0;
  logic in_delivered_in = 1'b0;
  logic [TIME_W-1:0] in_now_time = '0;
  logic out_valid;
  logic out_found;
  logic out_was_delivered;
  logic out_evicted;
  logic [CNT_W-1:0] out_removed_count;
  logic [CNT_W-1:0] out_entries_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LIFETIME;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // predictor copy of the table and registers
  entry_t cache_tbl [DEPTH];
  int unsigned cache_used = 0;
  logic [TIME_W-1:0] cache_lifetime = LIFETIME_RST;
  logic [CNT_W-1:0] cache_capacity = CAPACITY_RST;

  cache_op_t pending_ops [$];
  dedup_result_t expected_results [$];
  cache_op_t cur_op;

  key_t key_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_now = '0;
  int unsigned step_max = 1;
  int unsigned send_gap_pct = 10;

  int unsigned ops_queued = 0;
  int unsigned results_done = 0;
  int unsigned mismatches = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned culled_total = 0;
  int unsigned phases_run = 0;
  int unsigned stall_cycles = 0;

  seen_id_dedup_cache_unit #(.DEPTH(DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_key_word0      (in_key_word0),
    .in_key_word1      (in_key_word1),
    .in_key_word2      (in_key_word2),
    .in_key_word3      (in_key_word3),
    .in_delivered_in   (in_delivered_in),
    .in_now_time       (in_now_time),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_was_delivered (out_was_delivered),
    .out_evicted       (out_evicted),
    .out_removed_count (out_removed_count),
    .out_entries_used  (out_entries_used),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  function automatic logic is_stale(logic [TIME_W-1:0] seen, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    age = now - seen;
    return (seen == '0) || (now < seen) || (age > cache_lifetime);
  endfunction

  function automatic dedup_result_t cache_apply(cache_op_t op);
    dedup_result_t r;
    int hit;
    int unsigned lim;
    int unsigned keep;
    int unsigned i;
    r = '0;
    hit = -1;
    for (i = 0; i < cache_used; i++) begin
      if (hit < 0 && cache_tbl[i].key == op.key) hit = int'(i);
    end
    case (op.func)
      FUNC_LOOKUP: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.was_delivered = cache_tbl[hit].deliv;
        end
      end
      FUNC_REMEMBER: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          cache_tbl[hit].seen = op.now;
          cache_tbl[hit].deliv = cache_tbl[hit].deliv | op.deliv;
        end else begin
          lim = 32'(cache_capacity);
          if (lim == 0 || lim > DEPTH) lim = DEPTH;
          if (cache_used >= lim && cache_used > 0) begin
            for (i = 1; i < cache_used; i++) cache_tbl[i-1] = cache_tbl[i];
            cache_used--;
            r.evicted = 1'b1;
          end
          if (cache_used < DEPTH) begin
            cache_tbl[cache_used].key = op.key;
            cache_tbl[cache_used].seen = op.now;
            cache_tbl[cache_used].deliv = op.deliv;
            cache_used++;
          end
        end
      end
      FUNC_CULL: begin
        keep = 0;
        for (i = 0; i < cache_used; i++) begin
          if (!is_stale(cache_tbl[i].seen, op.now)) begin
            cache_tbl[keep] = cache_tbl[i];
            keep++;
          end
        end
        r.removed_count = CNT_W'(cache_used - keep);
        cache_used = keep;
      end
      default: begin
      end
    endcase
    r.entries_used = CNT_W'(cache_used);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic key_t random_key();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  task automatic queue_op(input logic [FUNC_W-1:0] func, input key_t key,
                          input logic deliv, input logic [TIME_W-1:0] now);
    cache_op_t op;
    op.func = func;
    op.key = key;
    op.deliv = deliv;
    op.now = now;
    pending_ops = {pending_ops, op};
    ops_queued++;
  endtask

  task automatic queue_random_op();
    int unsigned pick;
    int unsigned tpick;
    logic [FUNC_W-1:0] func;
    key_t key;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(0, 99);
    tpick = $urandom_range(0, 99);
    key = key_pool[$urandom_range(0, POOL_SIZE-1)];
    clock_now = clock_now + $urandom_range(0, step_max);
    now = clock_now;
    if (tpick < 3) now = clock_now - $urandom_range(1, 4 * step_max + 1);
    else if (tpick < 5) now = '0;
    else if (tpick < 7) now = $urandom;
    if (pick < 40) func = FUNC_REMEMBER;
    else if (pick < 72) func = FUNC_LOOKUP;
    else if (pick < 84) func = FUNC_CULL;
    else if (pick < 90) begin
      func = FUNC_REMEMBER;
      key = random_key();
    end else if (pick < 96) begin
      func = FUNC_LOOKUP;
      key = random_key();
    end else begin
      func = FUNC_UNUSED;
      key = random_key();
    end
    queue_op(func, key, 1'($urandom_range(0, 1)), now);
  endtask

  task automatic wait_drained();
    while (results_done < ops_queued) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LIFETIME) cache_lifetime = data;
    else cache_capacity = data[CNT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned gap_pct, input logic [31:0] lifetime,
                           input logic [31:0] cap_word, input int unsigned step,
                           input int unsigned count);
    write_reg(REG_LIFETIME, lifetime);
    write_reg(REG_CAPACITY, cap_word);
    send_gap_pct = gap_pct;
    step_max = (step == 0) ? 1 : step;
    repeat (count) queue_random_op();
    wait_drained();
    phases_run++;
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results = {expected_results, cache_apply(cur_op)};
      if (!start || !busy) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          cur_op = pending_ops.pop_front();
          start <= 1'b1;
          in_func <= cur_op.func;
          in_key_word0 <= cur_op.key[0];
          in_key_word1 <= cur_op.key[1];
          in_key_word2 <= cur_op.key[2];
          in_key_word3 <= cur_op.key[3];
          in_delivered_in <= cur_op.deliv;
          in_now_time <= cur_op.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dedup_result_t got;
    dedup_result_t want;
    if (rst_n && out_valid) begin
      results_done++;
      got = {out_found, out_was_delivered, out_evicted, out_removed_count, out_entries_used};
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with no item outstanding: found=%0b del=%0b evict=%0b "
                   , $time, got.found, got.was_delivered, got.evicted,
                   "removed=%0d used=%0d", got.removed_count, got.entries_used);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        hits_seen += want.found;
        evictions_seen += want.evicted;
        culled_total += want.removed_count;
        if (got !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch exp found=%0b del=%0b evict=%0b removed=%0d used=%0d",
                     $time, want.found, want.was_delivered, want.evicted,
                     want.removed_count, want.entries_used,
                     " got found=%0b del=%0b evict=%0b removed=%0d used=%0d",
                     got.found, got.was_delivered, got.evicted,
                     got.removed_count, got.entries_used);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    key_t k1;
    key_t k1b;
    logic [31:0] life_pick;
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = random_key();
      if (i % 4 == 3) begin
        key_pool[i] = key_pool[i-1];
        key_pool[i][$urandom_range(0, KEY_WORDS-1)] = rand_word();
      end
    end
    k1 = random_key();
    k1b = k1;
    k1b[3] = ~k1[3];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed item list, reset settings
    queue_op(FUNC_LOOKUP, '0, 1'b0, 32'd0);
    queue_op(FUNC_REMEMBER, '1, 1'b1, 32'hFFFF_FFFF);
    queue_op(FUNC_LOOKUP, '1, 1'b0, 32'd5);
    queue_op(FUNC_REMEMBER, '0, 1'b0, 32'd0);
    queue_op(FUNC_REMEMBER, k1, 1'b0, 32'd1000);
    queue_op(FUNC_REMEMBER, k1b, 1'b1, 32'd1000);
    queue_op(FUNC_REMEMBER, k1, 1'b1, 32'd1500);
    queue_op(FUNC_REMEMBER, k1, 1'b0, 32'd1600);
    queue_op(FUNC_LOOKUP, k1, 1'b0, 32'd1600);
    queue_op(FUNC_LOOKUP, k1b, 1'b1, 32'd1600);
    queue_op(FUNC_UNUSED, random_key(), 1'b1, $urandom);
    queue_op(FUNC_CULL, k1, 1'b0, 32'd2000);
    queue_op(FUNC_CULL, '0, 1'b0, 32'd4600);
    queue_op(FUNC_CULL, '1, 1'b1, 32'd4601);
    queue_op(FUNC_LOOKUP, k1b, 1'b0, 32'd4601);
    queue_op(FUNC_LOOKUP, '0, 1'b0, 32'd4601);
    queue_op(FUNC_LOOKUP, k1, 1'b0, 32'd4601);
    wait_drained();

    clock_now = $urandom;
    run_phase(10, 32'd3600, 32'd0, 150, 320);
    run_phase(10, 32'd0, 32'd1, 3, 200);
    clock_now = 32'hFFFF_F000;
    run_phase(10, 32'hFFFF_FFFF, 32'd16, 1000, 300);
    // capacity dropped below a full table, upper data bits set
    run_phase(55, 32'd1000, 32'h5A5A_5A43, 40, 300);
    life_pick = $urandom_range(200, 2000);
    run_phase(55, life_pick, 32'd20, life_pick / 25, 300);
    clock_now = $urandom;
    run_phase(0, $urandom, $urandom_range(0, 31), 300, 300);
    run_phase(0, 32'd3600, 32'd8, 150, 200);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items over %0d setting phases, %0d results checked, %0d mismatches",
             ops_queued, phases_run, results_done, mismatches);
    $display("hits %0d, evictions %0d, entries culled %0d",
             hits_seen, evictions_seen, culled_total);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sidc_pkg.sv
hw/rtl/sidc_cell.sv
hw/rtl/seen_id_dedup_cache_unit.sv
hw/rtl/sidc_checker.sv
dv/tb_seen_id_dedup_cache_unit.sv
